### src/first_fit_range_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// first fit range allocator assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_RANGE_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FFRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define FFRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, active during reset
`define FFRA_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types, status codes and controller commands of the range allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_size;
    logic [31:0] request_offset;
  } in_req_t;

  typedef struct packed {
    logic [31:0] granted_offset;
    logic [2:0]  status;
  } out_res_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_ACCEPT, OP_IDX_INC, OP_SLOT_TAKE, OP_FREAD,
    OP_SHRINK, OP_TAKE_ALL, OP_RECW, OP_DN_RD, OP_DN_WR, OP_DN_END,
    OP_RREAD, OP_REC_HIT, OP_PREV, OP_CUR, OP_MERGE_BOTH, OP_MERGE_L,
    OP_MERGE_R, OP_INS_START, OP_UP_RD, OP_UP_WR, OP_UP_END, OP_FINOK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       st_we;
    logic [2:0] st_code;
  } cmd_t;

  typedef struct packed {
    logic mode_free;
    logic size_zero;
    logic slot_busy;
    logic idx_last_rec;
    logic idx_ge_cnt;
    logic fit;
    logic exact;
    logic rec_match;
    logic start_gt;
    logic left;
    logic right;
    logic tbl_full;
    logic dn_end;
    logic up_end;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// request sequencer: record scan, free table scan, shifts and merges
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl
  import ffra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output cmd_t          cmd
);

  typedef enum logic [17:0] {
    S_INIT  = 18'h00001,
    S_IDLE  = 18'h00002,
    S_START = 18'h00004,
    S_VSCAN = 18'h00008,
    S_FRD   = 18'h00010,
    S_FCHK  = 18'h00020,
    S_RECW  = 18'h00040,
    S_DNRD  = 18'h00080,
    S_DNWR  = 18'h00100,
    S_RRD   = 18'h00200,
    S_RCHK  = 18'h00400,
    S_PRD   = 18'h00800,
    S_PCHK  = 18'h01000,
    S_DEC   = 18'h02000,
    S_UPRD  = 18'h04000,
    S_UPWR  = 18'h08000,
    S_FINOK = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NOP;
    cmd.st_we   = 1'b0;
    cmd.st_code = ST_OK;
    unique case (state_r)
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_START;
        end
      end
      S_START: begin
        priority if (stat.mode_free) begin
          state_nxt = S_RRD;
        end else if (stat.size_zero) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_ZERO;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_VSCAN;
        end
      end
      S_VSCAN: begin
        priority if (!stat.slot_busy) begin
          cmd.op    = OP_SLOT_TAKE;
          state_nxt = S_FRD;
        end else if (stat.idx_last_rec) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_FULL;
          state_nxt   = S_DONE;
        end else begin
          cmd.op = OP_IDX_INC;
        end
      end
      S_FRD: begin
        if (stat.idx_ge_cnt) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_NOFIT;
          state_nxt   = S_DONE;
        end else begin
          cmd.op    = OP_FREAD;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        priority if (stat.exact) begin
          cmd.op    = OP_TAKE_ALL;
          state_nxt = S_DNRD;
        end else if (stat.fit) begin
          cmd.op    = OP_SHRINK;
          state_nxt = S_RECW;
        end else begin
          cmd.op    = OP_IDX_INC;
          state_nxt = S_FRD;
        end
      end
      S_RECW: begin
        cmd.op      = OP_RECW;
        cmd.st_we   = 1'b1;
        cmd.st_code = ST_OK;
        state_nxt   = S_DONE;
      end
      S_DNRD: begin
        if (stat.dn_end) begin
          cmd.op    = OP_DN_END;
          state_nxt = stat.mode_free ? S_FINOK : S_RECW;
        end else begin
          cmd.op    = OP_DN_RD;
          state_nxt = S_DNWR;
        end
      end
      S_DNWR: begin
        cmd.op    = OP_DN_WR;
        state_nxt = S_DNRD;
      end
      S_RRD: begin
        cmd.op    = OP_RREAD;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        priority if (stat.rec_match) begin
          cmd.op    = OP_REC_HIT;
          state_nxt = S_PRD;
        end else if (stat.idx_last_rec) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_UNKNOWN;
          state_nxt   = S_DONE;
        end else begin
          cmd.op    = OP_IDX_INC;
          state_nxt = S_RRD;
        end
      end
      S_PRD: begin
        if (stat.idx_ge_cnt) begin
          state_nxt = S_DEC;
        end else begin
          cmd.op    = OP_FREAD;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat.start_gt) begin
          cmd.op    = OP_CUR;
          state_nxt = S_DEC;
        end else begin
          cmd.op    = OP_PREV;
          state_nxt = S_PRD;
        end
      end
      S_DEC: begin
        priority if (stat.left && stat.right) begin
          cmd.op    = OP_MERGE_BOTH;
          state_nxt = S_DNRD;
        end else if (stat.left) begin
          cmd.op    = OP_MERGE_L;
          state_nxt = S_FINOK;
        end else if (stat.right) begin
          cmd.op    = OP_MERGE_R;
          state_nxt = S_FINOK;
        end else if (stat.tbl_full) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_FULL;
          state_nxt   = S_DONE;
        end else begin
          cmd.op    = OP_INS_START;
          state_nxt = S_UPRD;
        end
      end
      S_UPRD: begin
        if (stat.up_end) begin
          cmd.op    = OP_UP_END;
          state_nxt = S_FINOK;
        end else begin
          cmd.op    = OP_UP_RD;
          state_nxt = S_UPWR;
        end
      end
      S_UPWR: begin
        cmd.op    = OP_UP_WR;
        state_nxt = S_UPRD;
      end
      S_FINOK: begin
        cmd.op      = OP_FINOK;
        cmd.st_we   = 1'b1;
        cmd.st_code = ST_OK;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// allocator datapath: free table and record rams, index and count registers
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_dp
  import ffra_pkg::*;
#(
  parameter int FREE_ENTRIES   = 64,
  parameter int RECORD_ENTRIES = 64,
  parameter int ADDR_BITS      = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire in_req_t in_data,
  input  wire cmd_t    cmd,
  output dp_stat_t     stat,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_res_t     out_data
);

  localparam int LW   = ADDR_BITS + 1;
  localparam int FEW  = ADDR_BITS + LW;
  localparam int REW  = ADDR_BITS + 32;
  localparam int CW   = (LW > 33) ? LW : 33;
  localparam int OW   = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int MX   = (FREE_ENTRIES > RECORD_ENTRIES) ? FREE_ENTRIES : RECORD_ENTRIES;
  localparam int IW   = $clog2(MX + 1);
  localparam int CNW  = $clog2(FREE_ENTRIES + 1);
  localparam int FAW  = $clog2(FREE_ENTRIES);
  localparam int RAW  = (RECORD_ENTRIES > 1) ? $clog2(RECORD_ENTRIES) : 1;

  in_req_t               req_r;
  logic [IW-1:0]         idx_r, tgt_r;
  logic [RAW-1:0]        slot_r;
  logic [CNW-1:0]        cnt_r;
  logic [RECORD_ENTRIES-1:0] valid_r;
  logic [ADDR_BITS-1:0]  loc_r;
  logic [31:0]           rlen_r;
  logic [31:0]           grant_r;
  logic [2:0]            st_r;
  logic [FEW-1:0]        prev_r, cur_r;
  logic                  out_valid_r;
  out_res_t              out_data_r;

  logic                  f_we, f_re, r_we, r_re;
  logic [FAW-1:0]        f_waddr, f_raddr;
  logic [FEW-1:0]        f_wdata, f_rdata;
  logic [REW-1:0]        r_wdata, r_rdata;

  logic [IW-1:0]         idx_p1, idx_m1;
  logic [ADDR_BITS-1:0]  fr_start, pv_start, cu_start, rr_start;
  logic [LW-1:0]         fr_len, pv_len, cu_len, rlen_x, end_x;
  logic [31:0]           rr_len;

  assign idx_p1   = idx_r + IW'(1);
  assign idx_m1   = idx_r - IW'(1);
  assign fr_start = f_rdata[FEW-1:LW];
  assign fr_len   = f_rdata[LW-1:0];
  assign pv_start = prev_r[FEW-1:LW];
  assign pv_len   = prev_r[LW-1:0];
  assign cu_start = cur_r[FEW-1:LW];
  assign cu_len   = cur_r[LW-1:0];
  assign rr_start = r_rdata[REW-1:32];
  assign rr_len   = r_rdata[31:0];
  assign rlen_x   = LW'(rlen_r);
  assign end_x    = LW'(loc_r) + rlen_x;

  ffra_ram #(.WIDTH(FEW), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk(clk), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
    .rd_en(f_re), .rd_addr(f_raddr), .rd_data(f_rdata)
  );

  ffra_ram #(.WIDTH(REW), .DEPTH(RECORD_ENTRIES)) u_rec_ram (
    .clk(clk), .wr_en(r_we), .wr_addr(slot_r), .wr_data(r_wdata),
    .rd_en(r_re), .rd_addr(idx_r[RAW-1:0]), .rd_data(r_rdata)
  );

  // status toward the controller
  always_comb begin
    stat.mode_free    = (req_r.mode == MODE_FREE);
    stat.size_zero    = (req_r.request_size == 32'd0);
    stat.slot_busy    = valid_r[idx_r[RAW-1:0]];
    stat.idx_last_rec = (idx_r == IW'(RECORD_ENTRIES - 1));
    stat.idx_ge_cnt   = (idx_r >= IW'(cnt_r));
    stat.fit          = (CW'(fr_len) >= CW'(req_r.request_size));
    stat.exact        = (CW'(fr_len) == CW'(req_r.request_size));
    stat.rec_match    = valid_r[idx_r[RAW-1:0]] &&
                        (OW'(rr_start) == OW'(req_r.request_offset));
    stat.start_gt     = (fr_start > loc_r);
    stat.left         = (idx_r != IW'(0)) && ((LW'(pv_start) + pv_len) == LW'(loc_r));
    stat.right        = (idx_r < IW'(cnt_r)) && (LW'(cu_start) == end_x);
    stat.tbl_full     = (cnt_r == CNW'(FREE_ENTRIES));
    stat.dn_end       = ((IW + 1)'(idx_r) + (IW + 1)'(1)) >= (IW + 1)'(cnt_r);
    stat.up_end       = (idx_r == tgt_r);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  // ram port control
  always_comb begin
    f_we    = 1'b0;
    f_re    = 1'b0;
    f_waddr = idx_r[FAW-1:0];
    f_raddr = idx_r[FAW-1:0];
    f_wdata = f_rdata;
    r_we    = 1'b0;
    r_re    = 1'b0;
    r_wdata = {loc_r, rlen_r};
    unique case (cmd.op)
      OP_INIT: begin
        f_we    = 1'b1;
        f_waddr = FAW'(0);
        f_wdata = {ADDR_BITS'(0), LW'(1) << ADDR_BITS};
      end
      OP_FREAD: f_re = 1'b1;
      OP_SHRINK: begin
        f_we    = 1'b1;
        f_wdata = {ADDR_BITS'(LW'(fr_start) + LW'(req_r.request_size)),
                   fr_len - LW'(req_r.request_size)};
      end
      OP_DN_RD: begin
        f_re    = 1'b1;
        f_raddr = idx_p1[FAW-1:0];
      end
      OP_DN_WR: f_we = 1'b1;
      OP_MERGE_BOTH: begin
        f_we    = 1'b1;
        f_waddr = idx_m1[FAW-1:0];
        f_wdata = {pv_start, pv_len + rlen_x + cu_len};
      end
      OP_MERGE_L: begin
        f_we    = 1'b1;
        f_waddr = idx_m1[FAW-1:0];
        f_wdata = {pv_start, pv_len + rlen_x};
      end
      OP_MERGE_R: begin
        f_we    = 1'b1;
        f_wdata = {loc_r, cu_len + rlen_x};
      end
      OP_UP_RD: begin
        f_re    = 1'b1;
        f_raddr = idx_m1[FAW-1:0];
      end
      OP_UP_WR: f_we = 1'b1;
      OP_UP_END: begin
        f_we    = 1'b1;
        f_waddr = tgt_r[FAW-1:0];
        f_wdata = {loc_r, rlen_x};
      end
      OP_RREAD: r_re = 1'b1;
      OP_RECW:  r_we = 1'b1;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CNW'(1);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT) || (out_valid_r && out_stall);
      unique case (cmd.op)
        OP_DN_END: cnt_r <= cnt_r - CNW'(1);
        OP_UP_END: cnt_r <= cnt_r + CNW'(1);
        OP_RECW:   valid_r[slot_r] <= 1'b1;
        OP_FINOK:  valid_r[slot_r] <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      st_r <= cmd.st_code;
    end
    unique case (cmd.op)
      OP_ACCEPT: begin
        req_r   <= in_data;
        idx_r   <= '0;
        grant_r <= '0;
      end
      OP_IDX_INC, OP_PREV: idx_r <= idx_p1;
      OP_SLOT_TAKE: begin
        slot_r <= idx_r[RAW-1:0];
        idx_r  <= '0;
      end
      OP_SHRINK, OP_TAKE_ALL: begin
        loc_r   <= fr_start;
        rlen_r  <= req_r.request_size;
        grant_r <= 32'(fr_start);
      end
      OP_DN_WR: idx_r <= idx_p1;
      OP_REC_HIT: begin
        slot_r <= idx_r[RAW-1:0];
        loc_r  <= rr_start;
        rlen_r <= rr_len;
        idx_r  <= '0;
      end
      OP_CUR: cur_r <= f_rdata;
      OP_INS_START: begin
        tgt_r <= idx_r;
        idx_r <= IW'(cnt_r);
      end
      OP_UP_WR: idx_r <= idx_m1;
      OP_EMIT: begin
        out_data_r.granted_offset <= (st_r == ST_OK) ? grant_r : 32'd0;
        out_data_r.status         <= st_r;
      end
      default: begin
      end
    endcase
    if (cmd.op == OP_PREV) begin
      prev_r <= f_rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### src/first_fit_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_unit
// first fit range allocator with a sorted, coalescing free range table
// ----------------------------------------------------------------------------
// one request at a time; the allocate record scan checks one record per state visit,
// the free record scan reads and then checks each record; free table scan and shift
// read and then check or write each entry, plus control states;
//   the next request can be taken as the result goes out; an output stall holds both
// reset: free table entry 0 is written in the init state after reset, then
//   requests are taken; all records are invalid
`default_nettype none

module first_fit_range_allocator_unit
  import ffra_pkg::*;
#(
  parameter int FREE_ENTRIES   = 64,
  parameter int RECORD_ENTRIES = 64,
  parameter int ADDR_BITS      = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_res_t     out_data
);

  cmd_t     cmd;
  dp_stat_t stat;

  ffra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  ffra_dp #(
    .FREE_ENTRIES(FREE_ENTRIES), .RECORD_ENTRIES(RECORD_ENTRIES),
    .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

`default_nettype wire

### src/ffra_chk.sv
// ----------------------------------------------------------------------------
// ffra_chk
// port level checker for the range allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_range_allocator_unit_assert.svh"

module ffra_chk
  import ffra_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire in_req_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire out_res_t out_data
);

  `FFRA_ASSERT_RST(a_rst_quiet, !rst_n, !out_valid)
  `FFRA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `FFRA_ASSERT_IMP(a_err_zero, out_valid && out_data.status != ST_OK, out_data.granted_offset == 32'd0)
  `FFRA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `FFRA_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind first_fit_range_allocator_unit ffra_chk u_ffra_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);

`default_nettype wire
